/* sv/silu_pkg.sv */
`default_nettype none

package silu_pkg;

  localparam int unsigned MAX_INTERVALS = 4096;
  localparam int unsigned MAX_CHROMS    = 32;
  localparam int unsigned POS_WIDTH     = 32;

  localparam int unsigned IDX_W       = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W       = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned CHROM_W     = 5;
  localparam int unsigned CHROM_IDX_W = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
  localparam int unsigned ENTRY_W     = 2 * POS_WIDTH;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_START_END = 3'd1,
    ERR_UNSORTED  = 3'd2,
    ERR_REPEAT    = 3'd3,
    ERR_FULL      = 3'd4
  } err_e;

  typedef struct packed {
    kind_e                kind;
    logic [CHROM_W-1:0]   chrom_id;
    logic [POS_WIDTH-1:0] pos_or_start;
    logic [POS_WIDTH-1:0] interval_end;
  } in_word_t;

  typedef struct packed {
    logic             hit;
    err_e             error_code;
    logic [CNT_W-1:0] interval_count;
  } out_word_t;

  // update request from the sequencer into the chromosome table
  typedef struct packed {
    logic                   commit;
    logic                   new_chrom;
    logic [CHROM_IDX_W-1:0] chrom;
    logic [IDX_W-1:0]       base;
  } tbl_upd_t;

endpackage

`default_nettype wire

/* sv/silu_ram.sv */
`default_nettype none

module silu_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/silu_chrom_tbl.sv */
`default_nettype none

module silu_chrom_tbl
  import silu_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [CHROM_IDX_W-1:0] rd_idx_i,
  input  wire tbl_upd_t               upd_i,
  output logic      [IDX_W-1:0]       rd_base_o,
  output logic      [CNT_W-1:0]       rd_count_o,
  output logic                        rd_seen_o
);

  logic             seen_q  [MAX_CHROMS];
  logic [CNT_W-1:0] count_q [MAX_CHROMS];
  logic [IDX_W-1:0] base_q  [MAX_CHROMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHROMS; i++) begin
        seen_q[i]  <= 1'b0;
        count_q[i] <= '0;
      end
    end else if (upd_i.commit) begin
      if (upd_i.new_chrom) begin
        seen_q[upd_i.chrom]  <= 1'b1;
        count_q[upd_i.chrom] <= CNT_W'(1);
      end else begin
        count_q[upd_i.chrom] <= count_q[upd_i.chrom] + CNT_W'(1);
      end
    end
  end

  // base only matters once the chromosome is seen
  always_ff @(posedge clk_i) begin
    if (upd_i.commit && upd_i.new_chrom) begin
      base_q[upd_i.chrom] <= upd_i.base;
    end
  end

  assign rd_base_o  = base_q[rd_idx_i];
  assign rd_count_o = count_q[rd_idx_i];
  assign rd_seen_o  = seen_q[rd_idx_i];

endmodule

`default_nettype wire

/* sv/sorted_interval_mask_lookup.sv */
// Load word: result strobed on the cycle after start; next word taken then.
// Query word: lower-bound search over the chromosome's run, one interval memory read
// per step; the memory's registered read port sets the pace. One word in flight;
// busy high while searching.
// The receiver cannot stall: res_valid_o lasts exactly one cycle.
// Reset clears the chromosome counts and load state at once; no clearing pass.
`default_nettype none

module sorted_interval_mask_lookup
  import silu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  item_i,
  output logic           res_valid_o,
  output out_word_t      res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     first_q, first_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [CNT_W-1:0]     lim_q, lim_d;
  logic [CNT_W-1:0]     qcount_q, qcount_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [CHROM_W-1:0]   cur_chrom_q, cur_chrom_d;
  logic                 has_cur_q, has_cur_d;
  logic [POS_WIDTH-1:0] last_q, last_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic                 res_valid_q, res_valid_d;
  out_word_t            res_q, res_d;

  logic                   accept;
  logic                   in_range;
  logic [CHROM_IDX_W-1:0] tb_idx;
  logic [IDX_W-1:0]       tb_base;
  logic [CNT_W-1:0]       tb_count;
  logic                   tb_seen;
  logic                   new_chrom;
  err_e                   ld_err;
  logic                   commit;
  tbl_upd_t               upd;
  logic [CNT_W-1:0]       ld_count;

  logic [ENTRY_W-1:0]   rdata;
  logic [POS_WIDTH-1:0] rd_start, rd_end;
  logic [IDX_W-1:0]     raddr;
  logic [CNT_W-1:0]     half, mid, first_n, len_n, probe;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign in_range = (32'(item_i.chrom_id) < MAX_CHROMS);
  assign tb_idx   = item_i.chrom_id[CHROM_IDX_W-1:0];

  silu_chrom_tbl u_tbl (
    .clk_i,
    .rst_ni,
    .rd_idx_i  (tb_idx),
    .upd_i     (upd),
    .rd_base_o (tb_base),
    .rd_count_o(tb_count),
    .rd_seen_o (tb_seen)
  );

  // load checks, in priority order
  always_comb begin
    new_chrom = !has_cur_q || (item_i.chrom_id != cur_chrom_q);
    if (item_i.pos_or_start > item_i.interval_end) begin
      ld_err = ERR_START_END;
    end else if (!in_range) begin
      ld_err = ERR_FULL;
    end else if (new_chrom && tb_seen) begin
      ld_err = ERR_REPEAT;
    end else if (!new_chrom && (tb_count != '0) && (item_i.pos_or_start < last_q)) begin
      ld_err = ERR_UNSORTED;
    end else if (32'(used_q) >= MAX_INTERVALS) begin
      ld_err = ERR_FULL;
    end else begin
      ld_err = ERR_OK;
    end
  end

  assign commit = accept && (item_i.kind == KIND_LOAD) && (ld_err == ERR_OK);

  always_comb begin
    upd.commit    = commit;
    upd.new_chrom = new_chrom;
    upd.chrom     = tb_idx;
    upd.base      = used_q[IDX_W-1:0];
  end

  always_comb begin
    if (commit) begin
      ld_count = new_chrom ? CNT_W'(1) : tb_count + CNT_W'(1);
    end else begin
      ld_count = in_range ? tb_count : '0;
    end
  end

  silu_ram #(
    .DEPTH(MAX_INTERVALS),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk_i,
    .we_i   (commit),
    .waddr_i(used_q[IDX_W-1:0]),
    .wdata_i({item_i.pos_or_start, item_i.interval_end}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_start = rdata[ENTRY_W-1:POS_WIDTH];
  assign rd_end   = rdata[POS_WIDTH-1:0];

  // one lower-bound step on the entry read last cycle
  always_comb begin
    half = len_q >> 1;
    mid  = first_q + half;
    if (rd_end < pos_q) begin
      first_n = mid + CNT_W'(1);
      len_n   = len_q - half - CNT_W'(1);
    end else begin
      first_n = first_q;
      len_n   = half;
    end
  end

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    len_d       = len_q;
    lim_d       = lim_q;
    qcount_d    = qcount_q;
    pos_d       = pos_q;
    cur_chrom_d = cur_chrom_q;
    has_cur_d   = has_cur_q;
    last_d      = last_q;
    used_d      = used_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    probe       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.kind == KIND_LOAD) begin
            res_valid_d          = 1'b1;
            res_d.hit            = 1'b0;
            res_d.error_code     = ld_err;
            res_d.interval_count = ld_count;
            if (commit) begin
              used_d = used_q + CNT_W'(1);
              last_d = item_i.pos_or_start;
              if (new_chrom) begin
                cur_chrom_d = item_i.chrom_id;
                has_cur_d   = 1'b1;
              end
            end
          end else if (in_range && (tb_count != '0)) begin
            first_d  = CNT_W'(tb_base);
            len_d    = tb_count;
            lim_d    = CNT_W'(tb_base) + tb_count;
            qcount_d = tb_count;
            pos_d    = item_i.pos_or_start;
            probe    = CNT_W'(tb_base) + (tb_count >> 1);
            state_d  = ST_SEARCH;
          end else begin
            res_valid_d          = 1'b1;
            res_d.hit            = 1'b0;
            res_d.error_code     = ERR_OK;
            res_d.interval_count = '0;
          end
        end
      end
      ST_SEARCH: begin
        first_d = first_n;
        len_d   = len_n;
        if (len_n != '0) begin
          probe = first_n + (len_n >> 1);
        end else if (first_n >= lim_q) begin
          res_valid_d          = 1'b1;
          res_d.hit            = 1'b0;
          res_d.error_code     = ERR_OK;
          res_d.interval_count = qcount_q;
          state_d              = ST_IDLE;
        end else begin
          probe   = first_n;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_valid_d          = 1'b1;
        res_d.hit            = (rd_start <= pos_q) && (pos_q <= rd_end);
        res_d.error_code     = ERR_OK;
        res_d.interval_count = qcount_q;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    raddr = probe[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_chrom_q <= '0;
      has_cur_q   <= 1'b0;
      last_q      <= '0;
      used_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_chrom_q <= cur_chrom_d;
      has_cur_q   <= has_cur_d;
      last_q      <= last_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    len_q    <= len_d;
    lim_q    <= lim_d;
    qcount_q <= qcount_d;
    pos_q    <= pos_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
